// ===== rtl/gtlb_pkg.sv =====
// Package for the greedy text line breaker: field widths, limits, command
// and register-index codes shared by the interfaces and the core.
// No dependencies.
package gtlb_pkg;

    // Field widths of the text item and line record channels.
    localparam int CMD_W   = 2;
    localparam int BYTES_W = 3;
    localparam int GLYPH_W = 16;
    localparam int POS_W   = 17;
    localparam int WIDTH_W = 24;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Largest byte position the text may reach; positions saturate here.
    localparam int TEXT_BYTES = 65536;

    // Item kinds carried on the cmd field. Code 3 is unused and ignored.
    typedef enum logic [CMD_W-1:0] {
        CMD_CODE_POINT  = 2'd0,
        CMD_NEWLINE     = 2'd1,
        CMD_END_OF_TEXT = 2'd2
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRAP_ENABLE = 1'd0,
        REG_MAX_WIDTH   = 1'd1
    } t_reg_idx;

endpackage

// ===== rtl/gtlb_text_if.sv =====
// Valid/ready channel carrying one text item per transaction.
// Depends on gtlb_pkg for the field widths.
interface gtlb_text_if;
    import gtlb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [BYTES_W-1:0] byte_count;
    logic [GLYPH_W-1:0] glyph_width;

    modport source (output valid, output cmd, output byte_count, output glyph_width,
                    input ready);
    modport sink   (input valid, input cmd, input byte_count, input glyph_width,
                    output ready);
endinterface

// ===== rtl/gtlb_line_if.sv =====
// Valid/ready channel carrying one line record per transaction.
// Depends on gtlb_pkg for the field widths.
interface gtlb_line_if;
    import gtlb_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   line_offset;
    logic [POS_W-1:0]   line_bytes;
    logic [WIDTH_W-1:0] line_width;
    logic               last_line;

    modport source (output valid, output line_offset, output line_bytes,
                    output line_width, output last_line, input ready);
    modport sink   (input valid, input line_offset, input line_bytes,
                    input line_width, input last_line, output ready);
endinterface

// ===== rtl/greedy_text_line_breaker_core.sv =====
// Greedy text line breaker core: turns a stream of text items into line records.
// Depends on gtlb_pkg, gtlb_text_if and gtlb_line_if.
//
// The core takes one text item per clock cycle while its output is not stalled
// and returns at most one line record for it, in the cycle after the item is
// accepted. Every item is handled by combinational logic that updates the line
// state and loads the output register, so the input stays ready while the output
// register is empty or is being drained in the same cycle; a stalled output
// holds one record and back-pressures the input. A newline or end of text
// always closes a line; with wrapping enabled and a nonzero width limit, a code
// point that would push a non-empty line past the limit closes the line before
// it. End of text returns all line state to zero. Configuration writes take
// effect at once and are meant to be made while the core is idle.
module greedy_text_line_breaker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gtlb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gtlb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gtlb_text_if.sink                      i_item,
    gtlb_line_if.source                    o_line
);
    import gtlb_pkg::*;

    localparam logic [POS_W:0]   POS_LIMIT = (POS_W+1)'(TEXT_BYTES);
    localparam logic [WIDTH_W:0] WIDTH_SAT = {1'b0, {WIDTH_W{1'b1}}};

    // Configuration registers.
    logic               r_wrap_enable;
    logic [GLYPH_W-1:0] r_max_width;

    // Line state.
    logic [POS_W-1:0]   r_byte_pos, n_byte_pos;
    logic [POS_W-1:0]   r_open_start, n_open_start;
    logic [WIDTH_W-1:0] r_open_width, n_open_width;
    logic               r_nonempty, n_nonempty;

    // Output register.
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_start;
    logic [POS_W-1:0]   r_out_bytes;
    logic [WIDTH_W-1:0] r_out_width;
    logic               r_out_last;

    logic               accept;
    logic               emit;
    logic               emit_last;
    logic               limit_on;
    logic               wrap_break;
    logic [WIDTH_W:0]   trial_width;
    logic [WIDTH_W:0]   sum_width;
    logic [WIDTH_W-1:0] sat_width;
    logic [POS_W:0]     pos_sum;
    logic [POS_W-1:0]   pos_sat;
    logic [BYTES_W-1:0] pos_step;

    // Input is taken whenever the output register is free or being drained.
    assign i_item.ready = !r_out_valid || o_line.ready;
    assign accept       = i_item.valid && i_item.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_enable <= 1'b0;
            r_max_width   <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_WRAP_ENABLE: r_wrap_enable <= i_cfg_data[0];
                REG_MAX_WIDTH:   r_max_width   <= i_cfg_data[GLYPH_W-1:0];
                default:         r_wrap_enable <= r_wrap_enable;
            endcase
        end
    end

    // Width limit test and saturating width accumulation for a code point.
    assign limit_on    = r_wrap_enable && (r_max_width != '0);
    assign trial_width = {1'b0, r_open_width} + (WIDTH_W+1)'(i_item.glyph_width);
    assign wrap_break  = limit_on && r_nonempty
                         && (trial_width > (WIDTH_W+1)'(r_max_width));
    assign sum_width   = (wrap_break ? '0 : {1'b0, r_open_width})
                         + (WIDTH_W+1)'(i_item.glyph_width);
    assign sat_width   = (sum_width > WIDTH_SAT) ? WIDTH_SAT[WIDTH_W-1:0]
                                                 : sum_width[WIDTH_W-1:0];

    // Saturating byte position advance: a code point's byte count or one newline byte.
    assign pos_step = (t_cmd'(i_item.cmd) == CMD_NEWLINE) ? BYTES_W'(1) : i_item.byte_count;
    assign pos_sum  = {1'b0, r_byte_pos} + (POS_W+1)'(pos_step);
    assign pos_sat  = (pos_sum >= POS_LIMIT) ? POS_LIMIT[POS_W-1:0] : pos_sum[POS_W-1:0];

    // Next line state and whether this item closes a line.
    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_open_start = r_open_start;
        n_open_width = r_open_width;
        n_nonempty   = r_nonempty;
        emit         = 1'b0;
        emit_last    = 1'b0;
        case (t_cmd'(i_item.cmd))
            CMD_CODE_POINT: begin
                emit         = wrap_break;
                n_open_start = wrap_break ? r_byte_pos : r_open_start;
                n_open_width = sat_width;
                n_nonempty   = 1'b1;
                n_byte_pos   = pos_sat;
            end
            CMD_NEWLINE: begin
                emit         = 1'b1;
                n_byte_pos   = pos_sat;
                n_open_start = pos_sat;
                n_open_width = '0;
                n_nonempty   = 1'b0;
            end
            CMD_END_OF_TEXT: begin
                emit         = 1'b1;
                emit_last    = 1'b1;
                n_byte_pos   = '0;
                n_open_start = '0;
                n_open_width = '0;
                n_nonempty   = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_open_start <= '0;
            r_open_width <= '0;
            r_nonempty   <= 1'b0;
        end else if (accept) begin
            r_byte_pos   <= n_byte_pos;
            r_open_start <= n_open_start;
            r_open_width <= n_open_width;
            r_nonempty   <= n_nonempty;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_line.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output record payload, taken from the line as it stands before this item.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_start <= r_open_start;
            r_out_bytes <= r_byte_pos - r_open_start;
            r_out_width <= r_open_width;
            r_out_last  <= emit_last;
        end
    end

    assign o_line.valid       = r_out_valid;
    assign o_line.line_offset = r_out_start;
    assign o_line.line_bytes  = r_out_bytes;
    assign o_line.line_width  = r_out_width;
    assign o_line.last_line   = r_out_last;

    // The open line never starts beyond the current byte position.
    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_start <= r_byte_pos)
        else $error("open line start is past the byte position");

    // The byte position stays within the text limit.
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_pos} <= POS_LIMIT)
        else $error("byte position exceeds the text limit");

    // An empty open line carries no width.
    a_empty_zero_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_nonempty |-> (r_open_width == '0))
        else $error("empty open line has nonzero width");

    // End of text yields a last-line record and clears the position.
    a_end_of_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_cmd'(i_item.cmd) == CMD_END_OF_TEXT))
        |=> (r_out_valid && r_out_last && (r_byte_pos == '0) && !r_nonempty))
        else $error("end of text did not close the text");

endmodule
